@@ rtl/core/gno_pkg.sv @@
// Shared types, constants and the gradient selection function for the
// gradient noise octave generator. No dependencies.
package gno_pkg;

  localparam int TABLE_SIZE      = 256;
  localparam int CELL_W          = 8;
  localparam int FRAC_W          = 16;
  localparam int COORD_W         = CELL_W + FRAC_W;
  localparam int MAX_OCTAVES_DEF = 8;
  localparam int NOISE_W         = 20;
  localparam int OUT_W           = 19;
  localparam int CFG_W           = 17;
  localparam int CFG_IDX_W       = 2;
  localparam int AMP_W           = 17;
  localparam int GRAD_W          = 19;
  localparam int DELTA_W         = 18;
  localparam int MUL_A_W         = 24;
  localparam int MUL_B_W         = 18;
  localparam int PROD_W          = MUL_A_W + MUL_B_W;
  localparam int ONE             = 1 << FRAC_W;
  localparam int OUT_MAX         = 262143;
  localparam int OUT_MIN         = -262144;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIMENSION   = 2'd0,
    REG_OCTAVES     = 2'd1,
    REG_PERSISTENCE = 2'd2,
    REG_GAIN        = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic               is_eval;
    logic [CELL_W-1:0]  table_index;
    logic [CELL_W-1:0]  table_value;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } item_t;

  typedef struct packed {
    logic             three;
    logic [3:0]       octave_count;
    logic [CFG_W-1:0] persistence;
    logic [CFG_W-1:0] gain;
  } cfg_t;

  function automatic logic signed [GRAD_W-1:0] grad_dot(
    input logic [3:0]                h,
    input logic signed [DELTA_W-1:0] dx,
    input logic signed [DELTA_W-1:0] dy,
    input logic signed [DELTA_W-1:0] dz
  );
    logic signed [GRAD_W-1:0] a;
    logic signed [GRAD_W-1:0] b;
    a = (h < 4'd8) ? GRAD_W'(dx) : GRAD_W'(dy);
    if (h < 4'd4) begin
      b = GRAD_W'(dy);
    end else if ((h == 4'd12) || (h == 4'd14)) begin
      b = GRAD_W'(dx);
    end else begin
      b = GRAD_W'(dz);
    end
    if (h[1]) begin
      b = -b;
    end
    if (h[0]) begin
      a = -a;
    end
    return a + b;
  endfunction

endpackage

@@ rtl/core/gradient_noise_octave_generator_top.sv @@
// Top level of the gradient noise octave generator: configuration
// registers, front end queue and back end sequencer. Uses gno_pkg,
// gno_front and gno_back.
//
// Improved gradient noise summed over octaves, 2D or 3D. A load item
// (operation 0) writes one byte of the 256-entry permutation table and
// is taken while the back end is idle; load every entry an evaluation can
// reach before evaluating. An evaluate item occupies the back end until
// its result enters the output register, which it waits for while the
// register is full. Each octave uses one shared multiplier (fades,
// interpolations, amplitude) and one table read port (10 or 14 chained
// reads). Items queue two deep in front; one result waits in the output
// register. Write configuration only while the block is idle.
module gradient_noise_octave_generator_top #(
  parameter int MAX_OCTAVES = gno_pkg::MAX_OCTAVES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic                               in_operation,
  input  logic [gno_pkg::CELL_W-1:0]         in_table_index,
  input  logic [gno_pkg::CELL_W-1:0]         in_table_value,
  input  logic [gno_pkg::COORD_W-1:0]        in_x_coord,
  input  logic [gno_pkg::COORD_W-1:0]        in_y_coord,
  input  logic [gno_pkg::COORD_W-1:0]        in_z_coord,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic signed [gno_pkg::OUT_W-1:0]   out_noise_value,
  input  logic                               cfg_we,
  input  logic [gno_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gno_pkg::CFG_W-1:0]          cfg_data
);

  gno_pkg::cfg_t  cfg_r;
  logic           q_valid;
  gno_pkg::item_t q_item;
  logic           q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.three        <= 1'b0;
      cfg_r.octave_count <= 4'd5;
      cfg_r.persistence  <= 17'd16384;
      cfg_r.gain         <= 17'd49200;
    end else if (cfg_we) begin
      case (gno_pkg::cfg_reg_t'(cfg_index))
        gno_pkg::REG_DIMENSION:   cfg_r.three        <= cfg_data[0];
        gno_pkg::REG_OCTAVES:     cfg_r.octave_count <= cfg_data[3:0];
        gno_pkg::REG_PERSISTENCE: cfg_r.persistence  <= cfg_data;
        gno_pkg::REG_GAIN:        cfg_r.gain         <= cfg_data;
        default:                  cfg_r              <= cfg_r;
      endcase
    end
  end

  gno_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_operation   (in_operation),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_z_coord     (in_z_coord),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  gno_back #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .cfg             (cfg_r),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_noise_value (out_noise_value)
  );

endmodule

@@ rtl/core/gno_front.sv @@
// Front end: accepts items, classifies them as table load or evaluate,
// and holds them in a two-entry queue for the back end. Uses gno_pkg.
module gno_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_operation,
  input  logic [gno_pkg::CELL_W-1:0]    in_table_index,
  input  logic [gno_pkg::CELL_W-1:0]    in_table_value,
  input  logic [gno_pkg::COORD_W-1:0]   in_x_coord,
  input  logic [gno_pkg::COORD_W-1:0]   in_y_coord,
  input  logic [gno_pkg::COORD_W-1:0]   in_z_coord,
  output logic                          q_valid,
  output gno_pkg::item_t                q_item,
  input  logic                          q_pop
);

  gno_pkg::item_t q_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     cnt_r;
  logic           do_push;
  logic           do_pop;
  gno_pkg::item_t item_nxt;

  assign in_full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_r[rp_r];
  assign do_push = in_push && !in_full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    item_nxt.is_eval     = (in_operation == gno_pkg::OP_EVAL);
    item_nxt.table_index = in_table_index;
    item_nxt.table_value = in_table_value;
    item_nxt.x           = in_x_coord;
    item_nxt.y           = in_y_coord;
    item_nxt.z           = in_z_coord;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        q_r[wp_r] <= item_nxt;
        wp_r      <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ rtl/core/gno_back.sv @@
// Back end: permutation table memory, fade / gradient / lerp sequencer
// around one shared multiplier, octave accumulation and output register.
// Uses gno_pkg.
module gno_back #(
  parameter int MAX_OCTAVES = gno_pkg::MAX_OCTAVES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  gno_pkg::item_t              q_item,
  output logic                        q_pop,
  input  gno_pkg::cfg_t               cfg,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic signed [gno_pkg::OUT_W-1:0] out_noise_value
);

  localparam int FW      = gno_pkg::FRAC_W;
  localparam int NW      = gno_pkg::NOISE_W;
  localparam int AW      = gno_pkg::MUL_A_W;
  localparam int OCT_W   = $clog2(MAX_OCTAVES + 1);
  localparam int CMP_W   = (OCT_W > 4) ? OCT_W : 4;
  localparam int TOT_W   = 38 + $clog2(MAX_OCTAVES);
  localparam int LO_BITS = 19;
  localparam int HI_W    = TOT_W - LO_BITS;
  localparam int LO_W    = LO_BITS + gno_pkg::CFG_W;
  localparam int SHIFT   = FW + 16;
  localparam int FIN_W   = TOT_W + 19;
  localparam int RES_W   = FIN_W - SHIFT;
  localparam logic [3:0] LAST_RK_2D = 4'd9;
  localparam logic [3:0] LAST_RK_3D = 4'd13;
  localparam logic [2:0] LAST_LK_2D = 3'd2;
  localparam logic [2:0] LAST_LK_3D = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_FA, S_FB, S_FC, S_FD, S_RD, S_RDL, S_LM, S_LA,
    S_AM, S_AC, S_AP, S_FN0, S_FN1, S_FN2, S_OUT
  } state_t;

  state_t                            state_r;
  logic                              three_r;
  logic [gno_pkg::COORD_W-1:0]       cx_r, cy_r, cz_r;
  logic [OCT_W-1:0]                  oct_r;
  logic [gno_pkg::AMP_W-1:0]         amp_r;
  logic signed [TOT_W-1:0]           total_r;
  logic [1:0]                        fi_r;
  logic [FW-1:0]                     t2_r;
  logic [FW:0]                       fade_r [3];
  logic [3:0]                        rk_r;
  logic [gno_pkg::CELL_W-1:0]        h_r [14];
  logic [2:0]                        lk_r;
  logic signed [NW-1:0]              la_r;
  logic signed [NW-1:0]              l_r [7];
  logic [LO_W-1:0]                   lo_r;
  logic signed [FIN_W-1:0]           fin_r;
  logic                              ovalid_r;
  logic [gno_pkg::OUT_W-1:0]         out_r;
  logic [gno_pkg::CELL_W-1:0]        rd_r;
  logic signed [gno_pkg::PROD_W-1:0] prod_r;
  logic [gno_pkg::CELL_W-1:0]        mem [gno_pkg::TABLE_SIZE];

  logic                              mem_we;
  logic [gno_pkg::CELL_W-1:0]        raddr;
  logic [FW-1:0]                     t_sel;
  logic [21:0]                       p_full;
  logic signed [AW-1:0]              mul_a;
  logic signed [gno_pkg::MUL_B_W-1:0] mul_b;
  logic [gno_pkg::CFG_W-1:0]         pers_eff;
  logic [CMP_W-1:0]                  n_eff;
  logic [3:0]                        last_rk;
  logic [2:0]                        last_lk;
  logic signed [gno_pkg::DELTA_W-1:0] xf, yf, zf, x1, y1, z1;
  logic [3:0]                        ga_hash, gb_hash;
  logic [2:0]                        ga_corner, gb_corner;
  logic signed [gno_pkg::GRAD_W-1:0] ga, gb;
  logic signed [NW-1:0]              lerp_a, lerp_b;
  logic [FW:0]                       lerp_t;
  logic signed [NW:0]                diff;
  logic signed [NW-1:0]              noise;
  logic signed [HI_W-1:0]            hi_part;
  logic signed [FIN_W-1:0]           hi_ext;
  logic signed [RES_W-1:0]           res;
  logic [gno_pkg::CELL_W-1:0]        xc, yc, zc;

  assign q_pop           = (state_r == S_IDLE) && q_valid;
  assign mem_we          = q_pop && !q_item.is_eval;
  assign out_empty       = !ovalid_r;
  assign out_noise_value = $signed(out_r);

  assign last_rk = three_r ? LAST_RK_3D : LAST_RK_2D;
  assign last_lk = three_r ? LAST_LK_3D : LAST_LK_2D;
  assign noise   = three_r ? l_r[6] : l_r[2];
  assign hi_part = total_r[TOT_W-1:LO_BITS];
  assign res     = fin_r[FIN_W-1:SHIFT];
  assign hi_ext  = FIN_W'($signed(prod_r[HI_W+gno_pkg::MUL_B_W-1:0]));

  assign xc = cx_r[gno_pkg::COORD_W-1:FW];
  assign yc = cy_r[gno_pkg::COORD_W-1:FW];
  assign zc = cz_r[gno_pkg::COORD_W-1:FW];

  assign pers_eff = (cfg.persistence > gno_pkg::CFG_W'(gno_pkg::ONE)) ?
                    gno_pkg::CFG_W'(gno_pkg::ONE) : cfg.persistence;

  always_comb begin
    if (cfg.octave_count == 4'd0) begin
      n_eff = CMP_W'(1);
    end else if (CMP_W'(cfg.octave_count) > CMP_W'(MAX_OCTAVES)) begin
      n_eff = CMP_W'(MAX_OCTAVES);
    end else begin
      n_eff = CMP_W'(cfg.octave_count);
    end
  end

  // fade: t^3 * (6 t^2 - 15 t + 10), with t2 already reduced
  always_comb begin
    case (fi_r)
      2'd0:    t_sel = cx_r[FW-1:0];
      2'd1:    t_sel = cy_r[FW-1:0];
      default: t_sel = cz_r[FW-1:0];
    endcase
    p_full = 22'd6 * 22'(t2_r) + 22'(10 * gno_pkg::ONE) - 22'd15 * 22'(t_sel);
  end

  // table read addresses: cell hashes, then the corner hashes
  always_comb begin
    case (rk_r)
      4'd0:    raddr = xc;
      4'd1:    raddr = xc + 8'd1;
      4'd2:    raddr = h_r[0] + yc;
      4'd3:    raddr = h_r[0] + yc + 8'd1;
      4'd4:    raddr = h_r[1] + yc;
      4'd5:    raddr = h_r[1] + yc + 8'd1;
      4'd6:    raddr = h_r[2] + zc;
      4'd7:    raddr = h_r[4] + zc;
      4'd8:    raddr = h_r[3] + zc;
      4'd9:    raddr = h_r[5] + zc;
      4'd10:   raddr = h_r[2] + zc + 8'd1;
      4'd11:   raddr = h_r[4] + zc + 8'd1;
      4'd12:   raddr = h_r[3] + zc + 8'd1;
      4'd13:   raddr = h_r[5] + zc + 8'd1;
      default: raddr = xc;
    endcase
  end

  always_comb begin
    xf = $signed(gno_pkg::DELTA_W'(cx_r[FW-1:0]));
    yf = $signed(gno_pkg::DELTA_W'(cy_r[FW-1:0]));
    zf = $signed(gno_pkg::DELTA_W'(cz_r[FW-1:0]));
    x1 = xf - gno_pkg::DELTA_W'(gno_pkg::ONE);
    y1 = yf - gno_pkg::DELTA_W'(gno_pkg::ONE);
    z1 = zf - gno_pkg::DELTA_W'(gno_pkg::ONE);
  end

  // corner bit 0 picks x-1, bit 1 y-1, bit 2 z-1
  always_comb begin
    case (lk_r)
      3'd0: begin
        ga_hash = h_r[6][3:0];  ga_corner = 3'd0;
        gb_hash = h_r[7][3:0];  gb_corner = 3'd1;
      end
      3'd1: begin
        ga_hash = h_r[8][3:0];  ga_corner = 3'd2;
        gb_hash = h_r[9][3:0];  gb_corner = 3'd3;
      end
      3'd3: begin
        ga_hash = h_r[10][3:0]; ga_corner = 3'd4;
        gb_hash = h_r[11][3:0]; gb_corner = 3'd5;
      end
      3'd4: begin
        ga_hash = h_r[12][3:0]; ga_corner = 3'd6;
        gb_hash = h_r[13][3:0]; gb_corner = 3'd7;
      end
      default: begin
        ga_hash = h_r[6][3:0];  ga_corner = 3'd0;
        gb_hash = h_r[7][3:0];  gb_corner = 3'd1;
      end
    endcase
    ga = gno_pkg::grad_dot(ga_hash, ga_corner[0] ? x1 : xf,
                           ga_corner[1] ? y1 : yf, ga_corner[2] ? z1 : zf);
    gb = gno_pkg::grad_dot(gb_hash, gb_corner[0] ? x1 : xf,
                           gb_corner[1] ? y1 : yf, gb_corner[2] ? z1 : zf);
  end

  always_comb begin
    case (lk_r)
      3'd0, 3'd1, 3'd3, 3'd4: begin
        lerp_a = NW'(ga);
        lerp_b = NW'(gb);
        lerp_t = fade_r[0];
      end
      3'd2: begin
        lerp_a = l_r[0];
        lerp_b = l_r[1];
        lerp_t = fade_r[1];
      end
      3'd5: begin
        lerp_a = l_r[3];
        lerp_b = l_r[4];
        lerp_t = fade_r[1];
      end
      3'd6: begin
        lerp_a = l_r[2];
        lerp_b = l_r[5];
        lerp_t = fade_r[2];
      end
      default: begin
        lerp_a = '0;
        lerp_b = '0;
        lerp_t = '0;
      end
    endcase
    diff = (NW+1)'(lerp_b) - (NW+1)'(lerp_a);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_FA: begin
        mul_a = $signed(AW'(t_sel));
        mul_b = $signed(gno_pkg::MUL_B_W'(t_sel));
      end
      S_FB: begin
        mul_a = $signed(AW'(prod_r[2*FW-1:FW]));
        mul_b = $signed(gno_pkg::MUL_B_W'(t_sel));
      end
      S_FC: begin
        mul_a = $signed(AW'(p_full[19:0]));
        mul_b = $signed(gno_pkg::MUL_B_W'(prod_r[2*FW-1:FW]));
      end
      S_LM: begin
        mul_a = AW'(diff);
        mul_b = $signed(gno_pkg::MUL_B_W'(lerp_t));
      end
      S_AM: begin
        mul_a = AW'(noise);
        mul_b = $signed(gno_pkg::MUL_B_W'(amp_r));
      end
      S_AC: begin
        mul_a = $signed(AW'(amp_r));
        mul_b = $signed(gno_pkg::MUL_B_W'(pers_eff));
      end
      S_FN0: begin
        mul_a = $signed(AW'(total_r[LO_BITS-1:0]));
        mul_b = $signed(gno_pkg::MUL_B_W'(cfg.gain));
      end
      S_FN1: begin
        mul_a = AW'(hi_part);
        mul_b = $signed(gno_pkg::MUL_B_W'(cfg.gain));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_item.table_index] <= q_item.table_value;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      // a result leaving in S_OUT is replaced there by the next one
      if (out_pop && ovalid_r && (state_r != S_OUT)) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid && q_item.is_eval) begin
            three_r <= cfg.three;
            cx_r    <= q_item.x;
            cy_r    <= q_item.y;
            cz_r    <= cfg.three ? q_item.z : '0;
            oct_r   <= '0;
            amp_r   <= gno_pkg::AMP_W'(gno_pkg::ONE);
            total_r <= '0;
            fi_r    <= 2'd0;
            state_r <= S_FA;
          end
        end
        S_FA: state_r <= S_FB;
        S_FB: begin
          t2_r    <= prod_r[2*FW-1:FW];
          state_r <= S_FC;
        end
        S_FC: state_r <= S_FD;
        S_FD: begin
          fade_r[fi_r] <= prod_r[2*FW:FW];
          if (fi_r == (three_r ? 2'd2 : 2'd1)) begin
            rk_r    <= 4'd0;
            state_r <= S_RD;
          end else begin
            fi_r    <= fi_r + 2'd1;
            state_r <= S_FA;
          end
        end
        S_RD: begin
          // read data is registered, so it belongs to the previous address
          if (rk_r != 4'd0) begin
            h_r[rk_r - 4'd1] <= rd_r;
          end
          if (rk_r == last_rk) begin
            state_r <= S_RDL;
          end else begin
            rk_r <= rk_r + 4'd1;
          end
        end
        S_RDL: begin
          h_r[rk_r] <= rd_r;
          lk_r      <= 3'd0;
          state_r   <= S_LM;
        end
        S_LM: begin
          la_r    <= lerp_a;
          state_r <= S_LA;
        end
        S_LA: begin
          l_r[lk_r] <= la_r + prod_r[FW+NW-1:FW];
          if (lk_r == last_lk) begin
            state_r <= S_AM;
          end else begin
            lk_r    <= lk_r + 3'd1;
            state_r <= S_LM;
          end
        end
        S_AM: state_r <= S_AC;
        S_AC: begin
          total_r <= total_r + TOT_W'(prod_r);
          state_r <= S_AP;
        end
        S_AP: begin
          amp_r <= prod_r[2*FW:FW];
          // next octave: double the frequency
          cx_r  <= {cx_r[gno_pkg::COORD_W-2:0], 1'b0};
          cy_r  <= {cy_r[gno_pkg::COORD_W-2:0], 1'b0};
          cz_r  <= {cz_r[gno_pkg::COORD_W-2:0], 1'b0};
          if (CMP_W'(oct_r) + CMP_W'(1) == n_eff) begin
            state_r <= S_FN0;
          end else begin
            oct_r   <= oct_r + OCT_W'(1);
            fi_r    <= 2'd0;
            state_r <= S_FA;
          end
        end
        S_FN0: state_r <= S_FN1;
        S_FN1: begin
          lo_r    <= prod_r[LO_W-1:0];
          state_r <= S_FN2;
        end
        S_FN2: begin
          fin_r   <= (hi_ext <<< LO_BITS) + $signed(FIN_W'(lo_r));
          state_r <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!ovalid_r || out_pop) begin
            if (res > $signed(RES_W'(gno_pkg::OUT_MAX))) begin
              out_r <= gno_pkg::OUT_W'(gno_pkg::OUT_MAX);
            end else if (res < $signed(RES_W'(gno_pkg::OUT_MIN))) begin
              out_r <= gno_pkg::OUT_W'(gno_pkg::OUT_MIN);
            end else begin
              out_r <= res[gno_pkg::OUT_W-1:0];
            end
            ovalid_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ verif/gradient_noise_octave_generator_chk.sv @@
// Checker for the gradient noise octave generator: watches the load, result
// and configuration ports, predicts each noise value and compares it.
// Depends on gno_pkg for widths and register codes.
`timescale 1ns / 100ps

module gradient_noise_octave_generator_chk (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  input  logic                               in_full,
  input  logic                               in_operation,
  input  logic [gno_pkg::CELL_W-1:0]         in_table_index,
  input  logic [gno_pkg::CELL_W-1:0]         in_table_value,
  input  logic [gno_pkg::COORD_W-1:0]        in_x_coord,
  input  logic [gno_pkg::COORD_W-1:0]        in_y_coord,
  input  logic [gno_pkg::COORD_W-1:0]        in_z_coord,
  input  logic                               out_empty,
  input  logic                               out_pop,
  input  logic signed [gno_pkg::OUT_W-1:0]   out_noise_value,
  input  logic                               cfg_we,
  input  logic [gno_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gno_pkg::CFG_W-1:0]          cfg_data,
  output int                                 fail_count,
  output int                                 pending
);

  logic [7:0]                        perm_bytes [gno_pkg::TABLE_SIZE];
  logic                              three_d;
  logic [3:0]                        octaves;
  logic [gno_pkg::CFG_W-1:0]         persist;
  logic [gno_pkg::CFG_W-1:0]         gain;
  logic signed [gno_pkg::OUT_W-1:0]  noise_q [$];

  function automatic longint fade_q(longint t);
    longint t2, t3, p;
    t2 = (t * t) >>> gno_pkg::FRAC_W;
    t3 = (t2 * t) >>> gno_pkg::FRAC_W;
    p  = 6 * t2 + 10 * longint'(gno_pkg::ONE) - 15 * t;
    return (t3 * p) >>> gno_pkg::FRAC_W;
  endfunction

  function automatic longint lerp_q(longint t, longint a, longint b);
    return a + (((b - a) * t) >>> gno_pkg::FRAC_W);
  endfunction

  function automatic longint grad_q(logic [7:0] hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint a, b;
    h = hash[3:0];
    a = (h < 8) ? x : y;
    b = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    if (h[1]) b = -b;
    if (h[0]) a = -a;
    return a + b;
  endfunction

  function automatic logic [7:0] pb(logic [7:0] i);
    return perm_bytes[i];
  endfunction

  function automatic longint cell_noise(logic [23:0] cx, logic [23:0] cy, logic [23:0] cz,
                                        logic three);
    logic [7:0] xc, yc, zc, ha, hb, aa, ab, ba, bb;
    longint x, y, z, u, v, w, i1, i2, j1, j2;
    longint one;
    one = gno_pkg::ONE;
    xc = cx[23:16];
    yc = cy[23:16];
    zc = three ? cz[23:16] : 8'd0;
    x = longint'(cx[15:0]);
    y = longint'(cy[15:0]);
    z = three ? longint'(cz[15:0]) : 0;
    u = fade_q(x);
    v = fade_q(y);
    ha = pb(xc) + yc;
    hb = pb(xc + 8'd1) + yc;
    aa = pb(ha);
    ab = pb(ha + 8'd1);
    ba = pb(hb);
    bb = pb(hb + 8'd1);
    if (!three) begin
      i1 = lerp_q(u, grad_q(pb(aa), x, y, 0), grad_q(pb(ba), x - one, y, 0));
      i2 = lerp_q(u, grad_q(pb(ab), x, y - one, 0), grad_q(pb(bb), x - one, y - one, 0));
      return lerp_q(v, i1, i2);
    end
    w = fade_q(z);
    aa = aa + zc;
    ab = ab + zc;
    ba = ba + zc;
    bb = bb + zc;
    i1 = lerp_q(u, grad_q(pb(ab + 8'd1), x, y - one, z - one),
                grad_q(pb(bb + 8'd1), x - one, y - one, z - one));
    j1 = lerp_q(v, lerp_q(u, grad_q(pb(aa + 8'd1), x, y, z - one),
                          grad_q(pb(ba + 8'd1), x - one, y, z - one)), i1);
    i2 = lerp_q(u, grad_q(pb(ab), x, y - one, z), grad_q(pb(bb), x - one, y - one, z));
    j2 = lerp_q(v, lerp_q(u, grad_q(pb(aa), x, y, z), grad_q(pb(ba), x - one, y, z)), i2);
    return lerp_q(w, j2, j1);
  endfunction

  function automatic logic signed [gno_pkg::OUT_W-1:0] octave_sum(logic [23:0] x,
                                                                 logic [23:0] y,
                                                                 logic [23:0] z);
    int n;
    longint amp, pers, total, res;
    logic [23:0] cx, cy, cz;
    if (octaves == 4'd0) begin
      n = 1;
    end else if (int'(octaves) > gno_pkg::MAX_OCTAVES_DEF) begin
      n = gno_pkg::MAX_OCTAVES_DEF;
    end else begin
      n = int'(octaves);
    end
    pers = (persist > 17'd65536) ? 65536 : longint'(persist);
    amp = 65536;
    total = 0;
    for (int i = 0; i < n; i++) begin
      cx = x << i;
      cy = y << i;
      cz = z << i;
      total += cell_noise(cx, cy, cz, three_d) * amp;
      amp = (amp * pers) >>> 16;
    end
    res = (total * longint'(gain)) >>> (gno_pkg::FRAC_W + 16);
    if (res > gno_pkg::OUT_MAX) res = gno_pkg::OUT_MAX;
    if (res < gno_pkg::OUT_MIN) res = gno_pkg::OUT_MIN;
    return res[gno_pkg::OUT_W-1:0];
  endfunction

  assign pending = noise_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      three_d <= 1'b0;
      octaves <= 4'd5;
      persist <= 17'd16384;
      gain <= 17'd49200;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (gno_pkg::cfg_reg_t'(cfg_index))
          gno_pkg::REG_DIMENSION:   three_d <= cfg_data[0];
          gno_pkg::REG_OCTAVES:     octaves <= cfg_data[3:0];
          gno_pkg::REG_PERSISTENCE: persist <= cfg_data;
          gno_pkg::REG_GAIN:        gain <= cfg_data;
          default: ;
        endcase
      end
      // table writes land in transfer order, so predict right away
      if (in_push && !in_full) begin
        if (in_operation == gno_pkg::OP_LOAD) begin
          perm_bytes[in_table_index] = in_table_value;
        end else begin
          noise_q.push_back(octave_sum(in_x_coord, in_y_coord, in_z_coord));
        end
      end
      if (out_pop && !out_empty) begin
        if (noise_q.size() == 0) begin
          $display("%0t: unexpected noise result, expected none, actual %0d",
                   $time, out_noise_value);
          fail_count <= fail_count + 1;
        end else begin
          if (out_noise_value !== noise_q[0]) begin
            $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                     $time, noise_q[0], out_noise_value);
            fail_count <= fail_count + 1;
          end
          void'(noise_q.pop_front());
        end
      end
    end
  end

endmodule

@@ verif/gradient_noise_octave_generator_top_test.sv @@
// Testbench top for the gradient noise octave generator: clock, reset,
// table loads, evaluate stimulus over several settings, and the verdict.
// Depends on gno_pkg, the block and gradient_noise_octave_generator_chk.
`timescale 1ns / 100ps

module gradient_noise_octave_generator_top_test;

  localparam int CYCLE_LIMIT = 6000000;
  localparam int DRAIN_CYCLES = 500;
  localparam int PHASE_ITEMS = 230;

  logic                               clk;
  logic                               rst_n;
  logic                               in_push;
  logic                               in_full;
  logic                               in_operation;
  logic [gno_pkg::CELL_W-1:0]         in_table_index;
  logic [gno_pkg::CELL_W-1:0]         in_table_value;
  logic [gno_pkg::COORD_W-1:0]        in_x_coord;
  logic [gno_pkg::COORD_W-1:0]        in_y_coord;
  logic [gno_pkg::COORD_W-1:0]        in_z_coord;
  logic                               out_empty;
  logic                               out_pop;
  logic signed [gno_pkg::OUT_W-1:0]   out_noise_value;
  logic                               cfg_we;
  logic [gno_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [gno_pkg::CFG_W-1:0]          cfg_data;
  int                                 fail_count;
  int                                 pending;
  int                                 cycles;
  int                                 hold_cycles;
  bit                                 no_gaps;

  gradient_noise_octave_generator_top u_dut (.*);

  gradient_noise_octave_generator_chk u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // result side: random stalls, occasional long ones, and one long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (no_gaps) begin
        out_pop <= 1'b1;
      end else begin
        if ($urandom_range(0, 99) == 0) stall_left = int'($urandom_range(20, 120));
        out_pop <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send(logic op, logic [7:0] idx, logic [7:0] val,
                      logic [23:0] x, logic [23:0] y, logic [23:0] z);
    int gap;
    in_push <= 1'b1;
    in_operation <= op;
    in_table_index <= idx;
    in_table_value <= val;
    in_x_coord <= x;
    in_y_coord <= y;
    in_z_coord <= z;
    @(posedge clk);
    while (in_full) @(posedge clk);
    gap = 0;
    if (!no_gaps) begin
      gap = ($urandom_range(0, 19) == 0) ? int'($urandom_range(10, 60)) :
                                           int'($urandom_range(0, 2));
    end
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // a trailing load leaves no result to wait for, so allow the back end to settle
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(gno_pkg::cfg_reg_t idx, logic [gno_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_mode(logic three, logic [3:0] oct, logic [16:0] pers, logic [16:0] g);
    drain();
    write_reg(gno_pkg::REG_DIMENSION, {16'd0, three});
    write_reg(gno_pkg::REG_OCTAVES, {13'd0, oct});
    write_reg(gno_pkg::REG_PERSISTENCE, pers);
    write_reg(gno_pkg::REG_GAIN, g);
  endtask

  function automatic logic [23:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return {8'($urandom_range(0, 255)), 16'h0000};
      3: return {8'($urandom_range(0, 255)), 16'hFFFF};
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_items(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        send(gno_pkg::OP_LOAD, 8'($urandom), 8'($urandom), 24'($urandom),
             24'($urandom), 24'($urandom));
      end else begin
        send(gno_pkg::OP_EVAL, 8'($urandom), 8'($urandom), pick_coord(), pick_coord(),
             pick_coord());
      end
    end
  endtask

  task automatic corner_evals();
    send(gno_pkg::OP_EVAL, 8'h00, 8'h00, 24'h000000, 24'h000000, 24'h000000);
    send(gno_pkg::OP_EVAL, 8'hFF, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send(gno_pkg::OP_EVAL, 8'h00, 8'h00, 24'h010000, 24'hFF0000, 24'h7F0000);
    send(gno_pkg::OP_EVAL, 8'h00, 8'h00, 24'h00FFFF, 24'h008000, 24'hFF8000);
    send(gno_pkg::OP_EVAL, 8'h00, 8'h00, 24'h123456, 24'hABCDEF, 24'h00FFFF);
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_operation = gno_pkg::OP_LOAD;
    in_table_index = '0;
    in_table_value = '0;
    in_x_coord = '0;
    in_y_coord = '0;
    in_z_coord = '0;
    cfg_we = 1'b0;
    cfg_index = gno_pkg::REG_DIMENSION;
    cfg_data = '0;
    hold_cycles = 0;
    no_gaps = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole table first so no evaluation reads an unwritten entry
    for (int i = 0; i < gno_pkg::TABLE_SIZE; i++) begin
      send(gno_pkg::OP_LOAD, i[7:0], (i == 0) ? 8'hFF : ((i == 255) ? 8'h00 : 8'($urandom)),
           24'($urandom), 24'($urandom), 24'($urandom));
    end

    // reset settings, then extremes and the saturating cases
    corner_evals();
    set_mode(1'b1, 4'd8, 17'd65536, 17'd65536);
    corner_evals();
    set_mode(1'b0, 4'd1, 17'd0, 17'd0);
    corner_evals();
    set_mode(1'b1, 4'd0, 17'h1FFFF, 17'h1FFFF);
    corner_evals();
    set_mode(1'b0, 4'd15, 17'd40000, 17'h1FFFF);
    corner_evals();

    // back pressure: hold off the result side while items keep coming
    hold_cycles = 3000;
    random_items(PHASE_ITEMS);

    set_mode(1'b0, 4'd3, 17'd32768, 17'd49200);
    no_gaps = 1'b1;
    random_items(PHASE_ITEMS);
    no_gaps = 1'b0;

    for (int p = 0; p < 6; p++) begin
      set_mode(1'($urandom_range(0, 1)), 4'($urandom_range(1, 4) + ((p == 5) ? 4 : 0)),
               17'($urandom_range(0, 65536)), 17'($urandom_range(20000, 70000)));
      random_items(PHASE_ITEMS);
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
